[rtl/efwr_pkg.sv]
// Package for the event flag unit: sizes, command and status codes, request types.
// No dependencies.
package efwr_pkg;
    localparam int NUM_GROUPS   = 8;
    localparam int NUM_WAITERS  = 16;
    localparam int PATTERN_BITS = 32;
    localparam int TASK_BITS    = 8;
    localparam int GW = 3;
    localparam int WW = $clog2(NUM_WAITERS);
    localparam int WCW = $clog2(NUM_WAITERS + 1);

    localparam logic [2:0] K_SET = 3'd0, K_CLR = 3'd1, K_WAIT = 3'd2, K_CAN = 3'd3,
                           K_REF = 3'd4, K_CRE = 3'd5, K_DEL = 3'd6;
    localparam logic [2:0] S_OK = 3'd0, S_NOGRP = 3'd1, S_PAR = 3'd2, S_BUSY = 3'd3,
                           S_LIMIT = 3'd4, S_TMO = 3'd5, S_DLT = 3'd6, S_NOWAIT = 3'd7;

    typedef struct packed {
        logic [2:0]              kind;
        logic [2:0]              group;
        logic [PATTERN_BITS-1:0] pattern;
        logic [2:0]              wait_mode;
        logic                    poll_only;
        logic [TASK_BITS-1:0]    task_req;
        logic [7:0]              task_priority;
        logic                    allow_multi;
        logic                    by_priority;
    } t_req;

    typedef struct packed {
        logic [2:0]              status;
        logic [TASK_BITS-1:0]    task_out;
        logic [PATTERN_BITS-1:0] pattern_out;
        logic                    released;
        logic                    queued;
        logic                    last;
    } t_rsp;

    // waiter record held in RAM (valid bits live in flops)
    typedef struct packed {
        logic [GW-1:0]           grp;
        logic [TASK_BITS-1:0]    tsk;
        logic [7:0]              prio;
        logic [PATTERN_BITS-1:0] pat;
        logic [2:0]              mode;
        logic [15:0]             stamp;
    } t_wrec;
    localparam int WREC_BITS = $bits(t_wrec);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_RD, ST_PICK, ST_ACT, ST_DONE
    } t_state;
endpackage

[rtl/efwr_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module efwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/event_flag_wait_release_unit_core.sv]
// Top level of the event flag unit: group table in flops, waiter table in RAM.
// Depends on efwr_pkg and efwr_ram.
//
//  channel | signals                       | handshake
//  --------+-------------------------------+-------------------------------
//  request | i_start, o_busy, i_req        | taken when i_start && !o_busy
//  result  | o_strobe, o_rsp               | one cycle per result, no stall
//
// Simple commands go from setup straight to the done state. Set, delete, wait,
// reference and cancel scan the waiter RAM (one read per cycle; each pass has
// setup, read, pick and act); set and delete repeat the pass once per waiter
// taken off the walk, so up to ~17 passes.
// Each pass picks the queue-head waiter still eligible (cancel: lowest index);
// released waiters drop their valid bit; the next pass finds the next in order.
// Reset clears the group table, valid bits and arrival counter; RAM holds junk.
// The result side cannot stall: each result is shown exactly one cycle.
module event_flag_wait_release_unit_core
    import efwr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_strobe,
    output t_rsp o_rsp
);
    // group table
    logic [PATTERN_BITS-1:0] r_pat [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]   r_live, r_multi, r_prio;
    logic [NUM_WAITERS-1:0]  r_vld;
    // waiters already examined (not matching) during a set walk
    logic [NUM_WAITERS-1:0]  r_skip;
    logic [15:0]             r_arr;

    t_state r_st, n_st;
    t_req   r_req;
    logic [WCW-1:0] r_idx;        // address being read
    logic           r_rdv;        // RAM output belongs to r_idx-1
    logic [WW-1:0]  r_ridx;
    logic           r_have;       // best candidate found
    logic [WW-1:0]  r_best;
    t_wrec          r_brec;
    logic           r_anyq;       // group has any waiter
    logic           r_free_ok;
    logic [WW-1:0]  r_free;

    // RAM
    logic           w_we;
    logic [WW-1:0]  w_waddr;
    t_wrec          w_wdata, w_rd;
    efwr_ram #(.WIDTH(WREC_BITS), .DEPTH(NUM_WAITERS)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_idx[WW-1:0]), .o_rdata(w_rd)
    );

    logic [PATTERN_BITS-1:0] w_gpat;
    assign w_gpat = r_pat[r_req.group];

    function automatic logic f_match(logic [PATTERN_BITS-1:0] p, logic [PATTERN_BITS-1:0] w,
                                     logic [2:0] m);
        return m[0] ? ((p & w) != '0) : ((p & w) == w);
    endfunction

    // commands decided without a scan (DONE also ends a stopped set walk)
    function automatic logic i_req_simple(t_req q);
        logic live;
        live = r_live[q.group];
        if (q.kind > K_DEL || q.kind == K_CRE || q.kind == K_CLR) return 1'b1;
        if (q.kind == K_CAN) return 1'b0;
        if (!live) return 1'b1;
        return (q.kind == K_WAIT) && (q.pattern == '0);
    endfunction

    // candidate eligibility for the current pass
    logic w_elig, w_ahead;
    logic [15:0] w_age_c, w_age_b;
    always_comb begin
        w_age_c = r_arr - w_rd.stamp;
        w_age_b = r_arr - r_brec.stamp;
        if (r_req.kind == K_CAN)
            w_elig = r_vld[r_ridx] && (w_rd.tsk == r_req.task_req);
        else
            w_elig = r_vld[r_ridx] && !r_skip[r_ridx] && (w_rd.grp == r_req.group);
        // scan runs in index order, so ties keep the earlier entry
        if (r_req.kind == K_CAN)
            w_ahead = 1'b0;
        else if (r_prio[r_req.group] && (w_rd.prio != r_brec.prio))
            w_ahead = w_rd.prio < r_brec.prio;
        else
            w_ahead = w_age_c > w_age_b;
    end

    logic [PATTERN_BITS-1:0] w_after;
    always_comb begin
        w_after = w_gpat;
        if (r_brec.mode[2]) w_after = w_after & ~r_brec.pat;
        if (r_brec.mode[1]) w_after = '0;
    end

    t_rsp n_rsp;
    logic n_strobe;
    always_comb begin
        n_st     = r_st;
        n_strobe = 1'b0;
        n_rsp    = '0;
        n_rsp.last = 1'b1;
        w_we     = 1'b0;
        w_waddr  = r_free;
        w_wdata  = '0;
        case (r_st)
            ST_IDLE: if (i_start) n_st = ST_SCAN;
            ST_SCAN: begin
                n_st = ST_SCAN_RD;
                if (i_req_simple(r_req)) n_st = ST_DONE;
            end
            ST_SCAN_RD: if (!r_rdv && r_idx == WCW'(NUM_WAITERS)) n_st = ST_PICK;
            ST_PICK: n_st = ST_ACT;
            ST_ACT: begin
                n_st = ST_IDLE;
                n_strobe = 1'b1;
                case (r_req.kind)
                    K_SET: begin
                        n_rsp.pattern_out = w_gpat;
                        if (r_have && f_match(w_gpat, r_brec.pat, r_brec.mode)) begin
                            n_rsp.task_out = r_brec.tsk;
                            n_rsp.released = 1'b1;
                            n_rsp.last = 1'b0;
                            n_st = ST_SCAN;
                            if (r_brec.mode[1] || (r_brec.mode[2] && w_after == '0))
                                n_st = ST_DONE;
                        end else if (r_have) begin
                            n_strobe = 1'b0;
                            n_st = ST_SCAN;
                        end
                    end
                    K_DEL: begin
                        n_rsp.pattern_out = w_gpat;
                        if (r_have) begin
                            n_rsp.status = S_DLT;
                            n_rsp.task_out = r_brec.tsk;
                            n_rsp.released = 1'b1;
                            n_rsp.last = 1'b0;
                            n_st = ST_SCAN;
                        end
                    end
                    K_REF: begin
                        n_rsp.pattern_out = w_gpat;
                        n_rsp.task_out = r_have ? r_brec.tsk : '0;
                    end
                    K_CAN: begin
                        n_rsp.task_out = r_req.task_req;
                        if (r_have) begin
                            n_rsp.released = 1'b1;
                            n_rsp.pattern_out = r_pat[r_brec.grp];
                        end else
                            n_rsp.status = S_NOWAIT;
                    end
                    default: begin  // wait
                        n_rsp.task_out = r_req.task_req;
                        n_rsp.pattern_out = w_gpat;
                        if (r_anyq && !r_multi[r_req.group])
                            n_rsp.status = S_BUSY;
                        else if (f_match(w_gpat, r_req.pattern, r_req.wait_mode))
                            n_rsp.status = S_OK;
                        else if (r_req.poll_only)
                            n_rsp.status = S_TMO;
                        else if (!r_free_ok)
                            n_rsp.status = S_LIMIT;
                        else begin
                            n_rsp.queued = 1'b1;
                            w_we = 1'b1;
                            w_wdata.grp = r_req.group;
                            w_wdata.tsk = r_req.task_req;
                            w_wdata.prio = r_req.task_priority;
                            w_wdata.pat = r_req.pattern;
                            w_wdata.mode = r_req.wait_mode;
                            w_wdata.stamp = r_arr;
                        end
                    end
                endcase
            end
            ST_DONE: begin
                n_st = ST_IDLE;
                n_strobe = 1'b1;
                n_rsp.pattern_out = w_gpat;
                if (r_req.kind > K_DEL) begin
                    n_rsp.status = S_PAR;
                    n_rsp.pattern_out = '0;
                end else if (r_req.kind == K_CRE) begin
                    if (r_live[r_req.group]) n_rsp.status = S_LIMIT;
                    else n_rsp.pattern_out = r_req.pattern;
                end else if (!r_live[r_req.group]) begin
                    n_rsp.status = S_NOGRP;
                    n_rsp.pattern_out = '0;
                end else if (r_req.kind == K_CLR)
                    n_rsp.pattern_out = w_gpat & r_req.pattern;
                else if (r_req.kind == K_WAIT) begin
                    n_rsp.status = S_PAR;
                    n_rsp.task_out = r_req.task_req;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_busy = (r_st != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_live <= '0; r_multi <= '0; r_prio <= '0;
            r_vld <= '0; r_arr <= '0;
            o_strobe <= 1'b0;
            for (int g = 0; g < NUM_GROUPS; g++) r_pat[g] <= '0;
        end else begin
            r_st <= n_st;
            o_strobe <= n_strobe;
            o_rsp <= n_rsp;
            case (r_st)
                ST_IDLE: if (i_start) begin
                    r_req <= i_req;
                    r_skip <= '0;
                    if (i_req.kind == K_SET)
                        r_pat[i_req.group] <= r_pat[i_req.group] | i_req.pattern;
                end
                ST_SCAN: begin
                    r_idx <= '0; r_rdv <= 1'b0; r_have <= 1'b0;
                    r_anyq <= 1'b0; r_free_ok <= 1'b0;
                end
                ST_SCAN_RD: begin
                    if (r_idx != WCW'(NUM_WAITERS)) r_idx <= r_idx + 1'b1;
                    r_rdv <= (r_idx != WCW'(NUM_WAITERS));
                    r_ridx <= r_idx[WW-1:0];
                    if (r_rdv) begin
                        if (!r_vld[r_ridx] && !r_free_ok) begin
                            r_free_ok <= 1'b1; r_free <= r_ridx;
                        end
                        if (r_vld[r_ridx] && w_rd.grp == r_req.group) r_anyq <= 1'b1;
                        if (w_elig && (!r_have || w_ahead)) begin
                            r_have <= 1'b1; r_best <= r_ridx; r_brec <= w_rd;
                        end
                    end
                end
                ST_ACT: begin
                    case (r_req.kind)
                        K_SET: if (r_have) begin
                            if (f_match(w_gpat, r_brec.pat, r_brec.mode)) begin
                                r_vld[r_best] <= 1'b0;
                                r_pat[r_req.group] <= w_after;
                            end else
                                r_skip[r_best] <= 1'b1;
                        end
                        K_DEL: if (r_have) r_vld[r_best] <= 1'b0;
                               else r_live[r_req.group] <= 1'b0;
                        K_CAN: if (r_have) r_vld[r_best] <= 1'b0;
                        K_WAIT: begin
                            if (r_anyq && !r_multi[r_req.group]) ;
                            else if (f_match(w_gpat, r_req.pattern, r_req.wait_mode)) begin
                                if (r_req.wait_mode[1]) r_pat[r_req.group] <= '0;
                                else if (r_req.wait_mode[2])
                                    r_pat[r_req.group] <= w_gpat & ~r_req.pattern;
                            end else if (!r_req.poll_only && r_free_ok) begin
                                r_vld[r_free] <= 1'b1;
                                r_arr <= r_arr + 16'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_DONE: begin
                    if (r_req.kind == K_CRE && !r_live[r_req.group]) begin
                        r_live[r_req.group]  <= 1'b1;
                        r_multi[r_req.group] <= r_req.allow_multi;
                        r_prio[r_req.group]  <= r_req.by_priority;
                        r_pat[r_req.group]   <= r_req.pattern;
                    end else if (r_req.kind == K_CLR && r_live[r_req.group])
                        r_pat[r_req.group] <= w_gpat & r_req.pattern;
                end
                default: ;
            endcase
        end
    end
endmodule

[bench/tb_event_flag_wait_release_unit_core.sv]
// Testbench for event_flag_wait_release_unit_core: directed table, then random
// commands, each result checked against a local model of the flag unit.
// Depends on efwr_pkg and the RTL of the unit.
module tb_event_flag_wait_release_unit_core;
    import efwr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 200;
    localparam int N_DIRECTED     = 25;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_strobe;
    t_rsp o_rsp;

    event_flag_wait_release_unit_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Local model of the unit: group table and waiter table
    // ---------------------------------------------------------------
    logic [31:0] grp_flags [NUM_GROUPS];
    logic        grp_live  [NUM_GROUPS];
    logic        grp_multi [NUM_GROUPS];
    logic        grp_prio  [NUM_GROUPS];
    logic        wt_valid  [NUM_WAITERS];
    logic [2:0]  wt_grp    [NUM_WAITERS];
    logic [7:0]  wt_task   [NUM_WAITERS];
    logic [7:0]  wt_prio   [NUM_WAITERS];
    logic [31:0] wt_pat    [NUM_WAITERS];
    logic [2:0]  wt_mode   [NUM_WAITERS];
    logic [15:0] wt_stamp  [NUM_WAITERS];
    logic [15:0] arrival_cnt;

    t_rsp rsp_expected [$];   // results still owed by the unit
    int   fail_count;
    int   req_count;
    int   rsp_count;
    int   release_count;
    int   idle_cycles;

    function automatic t_rsp mk_rsp(logic [2:0] st, logic [7:0] tk, logic [31:0] pat,
                                    logic rel, logic q, logic lst);
        t_rsp r;
        r.status = st; r.task_out = tk; r.pattern_out = pat;
        r.released = rel; r.queued = q; r.last = lst;
        return r;
    endfunction

    function automatic logic flags_match(logic [31:0] flags, logic [31:0] wp,
                                         logic [2:0] mode);
        if (mode[0]) return (flags & wp) != 0;
        return (flags & wp) == wp;
    endfunction

    // waiter a is served before waiter b
    function automatic logic served_first(int a, int b, logic by_prio);
        logic [15:0] age_a;
        logic [15:0] age_b;
        if (by_prio && wt_prio[a] != wt_prio[b]) return wt_prio[a] < wt_prio[b];
        age_a = arrival_cnt - wt_stamp[a];
        age_b = arrival_cnt - wt_stamp[b];
        if (age_a != age_b) return age_a > age_b;
        return a < b;
    endfunction

    // waiter indexes of group g, queue head first
    function automatic void group_queue(logic [2:0] g, ref int order[$]);
        int t;
        order.delete();
        for (int i = 0; i < NUM_WAITERS; i++) begin
            if (wt_valid[i] && wt_grp[i] == g) begin
                order.push_back(i);
                for (int j = order.size() - 1; j > 0; j--) begin
                    if (!served_first(order[j], order[j-1], grp_prio[g])) break;
                    t = order[j]; order[j] = order[j-1]; order[j-1] = t;
                end
            end
        end
    endfunction

    function automatic void flags_reset();
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_flags[g] = '0; grp_live[g] = 0; grp_multi[g] = 0; grp_prio[g] = 0;
        end
        for (int i = 0; i < NUM_WAITERS; i++) wt_valid[i] = 0;
        arrival_cnt = '0;
    endfunction

    // apply one request to the model, queue the results it owes
    function automatic void predict_flags(t_req q);
        int order[$];
        int w;
        int slot;
        logic stop;
        logic [2:0] g;
        logic [31:0] prev;
        g = q.group;
        if (q.kind == 3'd7) begin
            rsp_expected.push_back(mk_rsp(S_PAR, 0, 0, 0, 0, 1));
            return;
        end
        if (q.kind == K_CAN) begin
            for (int i = 0; i < NUM_WAITERS; i++) begin
                if (wt_valid[i] && wt_task[i] == q.task_req) begin
                    wt_valid[i] = 0;
                    rsp_expected.push_back(mk_rsp(S_OK, q.task_req,
                                                  grp_flags[wt_grp[i]], 1, 0, 1));
                    return;
                end
            end
            rsp_expected.push_back(mk_rsp(S_NOWAIT, q.task_req, 0, 0, 0, 1));
            return;
        end
        if (q.kind == K_CRE) begin
            if (grp_live[g]) begin
                rsp_expected.push_back(mk_rsp(S_LIMIT, 0, grp_flags[g], 0, 0, 1));
            end else begin
                grp_live[g] = 1; grp_multi[g] = q.allow_multi;
                grp_prio[g] = q.by_priority; grp_flags[g] = q.pattern;
                rsp_expected.push_back(mk_rsp(S_OK, 0, q.pattern, 0, 0, 1));
            end
            return;
        end
        if (!grp_live[g]) begin
            rsp_expected.push_back(mk_rsp(S_NOGRP, 0, 0, 0, 0, 1));
            return;
        end
        case (q.kind)
            K_SET: begin
                grp_flags[g] |= q.pattern;
                group_queue(g, order);
                foreach (order[k]) begin
                    w = order[k];
                    stop = 0;
                    if (!flags_match(grp_flags[g], wt_pat[w], wt_mode[w])) continue;
                    rsp_expected.push_back(mk_rsp(S_OK, wt_task[w], grp_flags[g], 1, 0, 0));
                    wt_valid[w] = 0;
                    if (wt_mode[w][2]) begin
                        grp_flags[g] &= ~wt_pat[w];
                        if (grp_flags[g] == 0) stop = 1;
                    end
                    if (wt_mode[w][1]) begin
                        grp_flags[g] = '0;
                        stop = 1;
                    end
                    if (stop) break;
                end
                rsp_expected.push_back(mk_rsp(S_OK, 0, grp_flags[g], 0, 0, 1));
            end
            K_CLR: begin
                grp_flags[g] &= q.pattern;
                rsp_expected.push_back(mk_rsp(S_OK, 0, grp_flags[g], 0, 0, 1));
            end
            K_WAIT: begin
                prev = grp_flags[g];
                group_queue(g, order);
                if (q.pattern == 0) begin
                    rsp_expected.push_back(mk_rsp(S_PAR, q.task_req, prev, 0, 0, 1));
                end else if (order.size() != 0 && !grp_multi[g]) begin
                    rsp_expected.push_back(mk_rsp(S_BUSY, q.task_req, prev, 0, 0, 1));
                end else if (flags_match(prev, q.pattern, q.wait_mode)) begin
                    if (q.wait_mode[2]) grp_flags[g] &= ~q.pattern;
                    if (q.wait_mode[1]) grp_flags[g] = '0;
                    rsp_expected.push_back(mk_rsp(S_OK, q.task_req, prev, 0, 0, 1));
                end else if (q.poll_only) begin
                    rsp_expected.push_back(mk_rsp(S_TMO, q.task_req, prev, 0, 0, 1));
                end else begin
                    slot = -1;
                    for (int i = NUM_WAITERS - 1; i >= 0; i--)
                        if (!wt_valid[i]) slot = i;
                    if (slot < 0) begin
                        rsp_expected.push_back(mk_rsp(S_LIMIT, q.task_req, prev, 0, 0, 1));
                    end else begin
                        wt_valid[slot] = 1; wt_grp[slot] = g;
                        wt_task[slot] = q.task_req; wt_prio[slot] = q.task_priority;
                        wt_pat[slot] = q.pattern; wt_mode[slot] = q.wait_mode;
                        wt_stamp[slot] = arrival_cnt;
                        arrival_cnt++;
                        rsp_expected.push_back(mk_rsp(S_OK, q.task_req, prev, 0, 1, 1));
                    end
                end
            end
            K_REF: begin
                group_queue(g, order);
                rsp_expected.push_back(mk_rsp(S_OK, order.size() ? wt_task[order[0]] : 8'd0,
                                              grp_flags[g], 0, 0, 1));
            end
            default: begin   // delete: flush every waiter, free the group
                group_queue(g, order);
                foreach (order[k]) begin
                    rsp_expected.push_back(mk_rsp(S_DLT, wt_task[order[k]],
                                                  grp_flags[g], 1, 0, 0));
                    wt_valid[order[k]] = 0;
                end
                grp_live[g] = 0;
                rsp_expected.push_back(mk_rsp(S_OK, 0, grp_flags[g], 0, 0, 1));
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result checker: the unit cannot be stalled, so just sample
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            t_rsp exp_r;
            rsp_count <= rsp_count + 1;
            if (rsp_expected.size() == 0) begin
                $display("%0t unexpected result: got %p", $realtime, o_rsp);
                fail_count <= fail_count + 1;
            end else begin
                exp_r = rsp_expected.pop_front();
                if (exp_r.released) release_count <= release_count + 1;
                if (o_rsp !== exp_r) begin
                    $display("%0t result differs: expected %p actual %p",
                             $realtime, exp_r, o_rsp);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // watchdog: cycles without any request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (i_start && !o_busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("event_flag_wait_release_unit_core: mismatch");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    // directed rows; fixed_chk means the expected single result is typed in
    typedef struct {
        t_req req;
        logic fixed_chk;
        t_rsp fixed_rsp;
    } t_dir_row;

    t_dir_row dir_table [N_DIRECTED];
    logic     quiet_run;   // true during the stretch without sender gaps

    function automatic t_req mk_req(logic [2:0] k, logic [2:0] g, logic [31:0] p,
                                    logic [2:0] m, logic pl, logic [7:0] tk,
                                    logic [7:0] pr, logic am, logic bp);
        t_req r;
        r.kind = k; r.group = g; r.pattern = p; r.wait_mode = m; r.poll_only = pl;
        r.task_req = tk; r.task_priority = pr; r.allow_multi = am; r.by_priority = bp;
        return r;
    endfunction

    function automatic void dir_row(int i, t_req q, logic chk, t_rsp r);
        dir_table[i].req = q; dir_table[i].fixed_chk = chk; dir_table[i].fixed_rsp = r;
    endfunction

    // start stays high after the accepting edge; the unit is busy then, and
    // the next request either idles it low or replaces the payload
    task automatic send_request(t_req q);
        if (!quiet_run) begin
            while ($urandom_range(99) < 34) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_req   <= q;
        do @(posedge i_clk); while (o_busy);
        predict_flags(q);
        req_count++;
    endtask

    function automatic t_req rand_req();
        t_req q;
        int sel;
        q = mk_req($urandom_range(6), $urandom_range(7), $urandom, $urandom_range(7),
                   $urandom_range(9) == 0, $urandom_range(15) + 1,
                   $urandom_range(255), $urandom_range(3) != 0, $urandom_range(1));
        sel = $urandom_range(99);
        // weight toward waits and sets on few groups with sparse bits so
        // waiters pile up and get released in bunches
        if (sel < 40) q.kind = K_WAIT;
        else if (sel < 65) q.kind = K_SET;
        else if (sel < 72) q.kind = K_CRE;
        if (sel < 85) begin
            q.group = $urandom_range(2);
            q.pattern = $urandom_range(3) == 0 ? $urandom : (32'h1 << $urandom_range(31))
                        | (32'h1 << $urandom_range(3));
        end
        if (q.kind == K_CLR && $urandom_range(1)) q.pattern = ~q.pattern;
        if ($urandom_range(30) == 0) q.kind = 3'd7;
        if ($urandom_range(20) == 0) q.pattern = '0;
        if ($urandom_range(20) == 0) q.task_req = $urandom;
        return q;
    endfunction

    initial begin
        t_req q;
        fail_count = 0; req_count = 0; rsp_count = 0; release_count = 0;
        idle_cycles = 0; quiet_run = 0;
        flags_reset();
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, each error path
        dir_row(0,  mk_req(K_SET, 0, '1, 0, 0, 1, 0, 0, 0), 1, mk_rsp(S_NOGRP, 0, 0, 0, 0, 1));
        dir_row(1,  mk_req(3'd7, 7, 0, 0, 0, 0, 0, 0, 0), 1, mk_rsp(S_PAR, 0, 0, 0, 0, 1));
        dir_row(2,  mk_req(K_CAN, 0, 0, 0, 0, 8'hFF, 0, 0, 0), 1,
                mk_rsp(S_NOWAIT, 8'hFF, 0, 0, 0, 1));
        dir_row(3,  mk_req(K_CRE, 0, '0, 0, 0, 0, 0, 1, 1), 1, mk_rsp(S_OK, 0, 0, 0, 0, 1));
        dir_row(4,  mk_req(K_CRE, 0, '1, 0, 0, 0, 0, 0, 0), 1, mk_rsp(S_LIMIT, 0, 0, 0, 0, 1));
        dir_row(5,  mk_req(K_CRE, 7, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(S_OK, 0, 32'hFFFF_FFFF, 0, 0, 1));
        dir_row(6,  mk_req(K_WAIT, 0, '0, 0, 0, 5, 0, 0, 0), 1, mk_rsp(S_PAR, 5, 0, 0, 0, 1));
        dir_row(7,  mk_req(K_WAIT, 0, 32'h1, 0, 1, 5, 0, 0, 0), 1, mk_rsp(S_TMO, 5, 0, 0, 0, 1));
        dir_row(8,  mk_req(K_WAIT, 0, 32'h3, 0, 0, 8'd1, 8'd200, 0, 0), 0, '0);
        dir_row(9,  mk_req(K_WAIT, 0, 32'h1, 4, 0, 8'd2, 8'd255, 0, 0), 0, '0);
        dir_row(10, mk_req(K_WAIT, 0, 32'h8000_0000, 1, 0, 8'd3, 8'd0, 0, 0), 0, '0);
        dir_row(11, mk_req(K_REF, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        dir_row(12, mk_req(K_SET, 0, 32'h1, 0, 0, 0, 0, 0, 0), 0, '0);
        dir_row(13, mk_req(K_SET, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 0, '0);
        dir_row(14, mk_req(K_CLR, 7, 32'h0000_FFFF, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(S_OK, 0, 32'h0000_FFFF, 0, 0, 1));
        dir_row(15, mk_req(K_WAIT, 7, 32'h1, 0, 0, 8'd9, 0, 0, 0), 1,
                mk_rsp(S_OK, 9, 32'h0000_FFFF, 0, 0, 1));
        dir_row(16, mk_req(K_WAIT, 7, 32'h10000, 0, 0, 8'd10, 0, 0, 0), 0, '0);
        dir_row(17, mk_req(K_WAIT, 7, 32'h10000, 0, 0, 8'd11, 0, 0, 0), 0, '0);
        dir_row(18, mk_req(K_WAIT, 7, 32'hF, 2, 0, 8'd12, 0, 0, 0), 0, '0);
        dir_row(19, mk_req(K_CAN, 0, 0, 0, 0, 8'd10, 0, 0, 0), 0, '0);
        dir_row(20, mk_req(K_WAIT, 0, 32'h2, 6, 0, 8'd4, 8'd7, 0, 0), 0, '0);
        dir_row(21, mk_req(K_WAIT, 0, 32'h4, 0, 0, 8'd4, 8'd7, 0, 0), 0, '0);
        dir_row(22, mk_req(K_CLR, 0, 32'h0, 0, 0, 0, 0, 0, 0), 0, '0);
        dir_row(23, mk_req(K_DEL, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        dir_row(24, mk_req(K_DEL, 7, 0, 0, 0, 0, 0, 0, 0), 0, '0);

        // rows with a typed result owe exactly one result: the newest one queued
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(dir_table[i].req);
            if (dir_table[i].fixed_chk &&
                rsp_expected[$] !== dir_table[i].fixed_rsp) begin
                $display("%0t directed row %0d: expected %p actual %p", $realtime, i,
                         dir_table[i].fixed_rsp, rsp_expected[$]);
                fail_count++;
            end
        end

        // random: first a burst without gaps, then gaps at random
        for (int i = 0; i < N_RANDOM; i++) begin
            quiet_run = (i < 40);
            q = rand_req();
            send_request(q);
        end
        i_start <= 1'b0;

        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked, %0d waiter releases seen",
                 req_count, rsp_count, release_count);
        if (fail_count == 0 && rsp_expected.size() == 0)
            $display("event_flag_wait_release_unit_core: match");
        else
            $display("event_flag_wait_release_unit_core: mismatch");
        $finish;
    end
endmodule
